FILE: src/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: src/iacr_pkg.sv
`default_nettype none
package iacr_pkg;
	typedef enum logic [4:0] {
		OP_ADD    = 5'd0,
		OP_ADDI   = 5'd1,
		OP_ADDIS  = 5'd2,
		OP_ADDIC  = 5'd3,
		OP_ADDE   = 5'd4,
		OP_ADDZE  = 5'd5,
		OP_SUBF   = 5'd6,
		OP_SUBFC  = 5'd7,
		OP_SUBFIC = 5'd8,
		OP_SUBFE  = 5'd9,
		OP_SUBFME = 5'd10,
		OP_SUBFZE = 5'd11,
		OP_MULLW  = 5'd12,
		OP_MULLWU = 5'd13,
		OP_MULHW  = 5'd14,
		OP_MULHWU = 5'd15,
		OP_MULLI  = 5'd16,
		OP_DIVW   = 5'd17,
		OP_DIVWU  = 5'd18,
		OP_ABS    = 5'd19,
		OP_NABS   = 5'd20,
		OP_NEG    = 5'd21
	} op_t;

	localparam int unsigned OpLast = 21;
	localparam int unsigned Word   = 32;

	localparam logic [2:0] CR_LT = 3'b100;
	localparam logic [2:0] CR_GT = 3'b010;
	localparam logic [2:0] CR_EQ = 3'b001;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		KIND_ALU,
		KIND_MUL,
		KIND_DIV,
		KIND_NONE
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic read;
		logic exec;
		logic mul;
		logic div_start;
		logic div_step;
		logic finish;
		logic out_take;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		kind_t kind;
		logic  div_done;
	} stat_t;
endpackage
`default_nettype wire

FILE: src/integer_alu_with_carry_and_cr0.sv
// Channel  | Handshake          | Payload
// in       | in_valid/in_ready  | operation dest_index src_a_index src_b_index immediate record_flag
// out      | out_valid/out_ready| written_index written_value carry_now cond_now
// One transaction at a time. Add/sub/abs/neg: operand read, execute, write-back, then out_valid.
// Multiplies: one 33x33 multiply in place of execute. Divides: operand load,
// divider setup, 32 quotient bits at one per cycle, a result step and the write-back.
// Reset clears flags and register valid bits at once; no clearing pass.
// A stalled result holds until out_ready; in_ready is low until it is taken.
`default_nettype none
module integer_alu_with_carry_and_cr0 #(
	parameter int unsigned REG_COUNT = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire [4:0]         operation,
	input  wire [4:0]         dest_index,
	input  wire [4:0]         src_a_index,
	input  wire [4:0]         src_b_index,
	input  wire signed [15:0] immediate,
	input  wire               record_flag,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [4:0]        written_index,
	output logic [31:0]       written_value,
	output logic              carry_now,
	output logic [2:0]        cond_now
);
	iacr_pkg::cmd_t  cmd;
	iacr_pkg::stat_t stat;

	iacr_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd
	);

	iacr_datapath #(.REG_COUNT(REG_COUNT)) u_dp (
		.clk, .arst_n, .cmd, .stat,
		.operation, .dest_index, .src_a_index, .src_b_index, .immediate,
		.record_flag, .written_index, .written_value, .carry_now, .cond_now
	);
endmodule
`default_nettype wire

FILE: src/iacr_ctrl.sv
`default_nettype none
module iacr_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	input  iacr_pkg::stat_t     stat,
	output iacr_pkg::cmd_t      cmd
);
	iacr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iacr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			iacr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = iacr_pkg::ST_READ;
				end
			end
			iacr_pkg::ST_READ: begin
				cmd.read = 1'b1;
				case (stat.kind)
					iacr_pkg::KIND_MUL: state_d = iacr_pkg::ST_MUL;
					iacr_pkg::KIND_DIV: state_d = iacr_pkg::ST_DIV_INIT;
					default: state_d = iacr_pkg::ST_EXEC;
				endcase
			end
			iacr_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d = iacr_pkg::ST_FIN;
			end
			iacr_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = iacr_pkg::ST_FIN;
			end
			// operands are loaded now; set up the divider
			iacr_pkg::ST_DIV_INIT: begin
				cmd.div_start = 1'b1;
				state_d = iacr_pkg::ST_DIV;
			end
			iacr_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) state_d = iacr_pkg::ST_FIN;
			end
			iacr_pkg::ST_FIN: begin
				cmd.finish = 1'b1;
				state_d = iacr_pkg::ST_OUT;
			end
			iacr_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.out_take = 1'b1;
					state_d = iacr_pkg::ST_IDLE;
				end
			end
			default: state_d = iacr_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

FILE: src/iacr_datapath.sv
`default_nettype none
module iacr_datapath #(
	parameter int unsigned REG_COUNT = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  iacr_pkg::cmd_t       cmd,
	output iacr_pkg::stat_t      stat,
	input  wire [4:0]            operation,
	input  wire [4:0]            dest_index,
	input  wire [4:0]            src_a_index,
	input  wire [4:0]            src_b_index,
	input  wire signed [15:0]    immediate,
	input  wire                  record_flag,
	output logic [4:0]           written_index,
	output logic [31:0]          written_value,
	output logic                 carry_now,
	output logic [2:0]           cond_now
);
	localparam int unsigned IdxW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	// register file with per-entry valid bits (invalid reads as zero)
	logic [31:0]          rf_q [REG_COUNT];
	logic [REG_COUNT-1:0] rf_vld_q;

	logic [4:0]  op_q, rt_q, ra_i_q, rb_i_q;
	logic [31:0] imm_q;
	logic        rec_q;
	logic [31:0] a_q, b_q, rt_val_q;
	logic        carry_q;
	logic [2:0]  cond_q;
	logic [31:0] res_q;
	logic        nc_q;
	logic        wr_q;

	// divider
	logic [31:0] dv_quo_q, dv_rem_q, dv_den_q;
	logic [5:0]  dv_cnt_q;
	logic        dv_neg_q, dv_zero_q;

	function automatic logic [31:0] rd(input logic [4:0] idx,
			input logic [31:0] f [REG_COUNT], input logic [REG_COUNT-1:0] v);
		logic [31:0] r;
		r = '0;
		if (32'(idx) < REG_COUNT) begin
			if (v[idx[IdxW-1:0]]) r = f[idx[IdxW-1:0]];
		end
		return r;
	endfunction

	always_comb begin
		case (op_q)
			iacr_pkg::OP_MULLW, iacr_pkg::OP_MULLWU, iacr_pkg::OP_MULHW,
			iacr_pkg::OP_MULHWU, iacr_pkg::OP_MULLI: stat.kind = iacr_pkg::KIND_MUL;
			iacr_pkg::OP_DIVW, iacr_pkg::OP_DIVWU: stat.kind = iacr_pkg::KIND_DIV;
			default: stat.kind = (32'(op_q) > iacr_pkg::OpLast) ?
				iacr_pkg::KIND_NONE : iacr_pkg::KIND_ALU;
		endcase
		stat.div_done = (dv_cnt_q == 6'd0);
	end

	// ALU
	logic [31:0] alu_r, ra0;
	logic        alu_c;
	logic [32:0] s3;
	logic [31:0] x, y;
	logic        z;
	always_comb begin
		ra0   = (ra_i_q == 5'd0) ? 32'd0 : a_q;
		alu_r = rt_val_q;
		alu_c = carry_q;
		x = a_q; y = 32'd0; z = 1'b0;
		case (op_q)
			iacr_pkg::OP_ADDIC: begin x = a_q; y = imm_q; z = 1'b0; end
			iacr_pkg::OP_ADDE:  begin x = a_q; y = b_q; z = carry_q; end
			iacr_pkg::OP_ADDZE: begin x = a_q; y = 32'd0; z = carry_q; end
			iacr_pkg::OP_SUBFC: begin x = ~a_q; y = b_q; z = 1'b1; end
			iacr_pkg::OP_SUBFIC: begin x = ~a_q; y = imm_q; z = 1'b1; end
			iacr_pkg::OP_SUBFE: begin x = ~a_q; y = b_q; z = carry_q; end
			iacr_pkg::OP_SUBFME: begin x = ~a_q; y = 32'hFFFF_FFFF; z = carry_q; end
			iacr_pkg::OP_SUBFZE: begin x = ~a_q; y = 32'd0; z = carry_q; end
			default: begin x = a_q; y = 32'd0; z = 1'b0; end
		endcase
		s3 = {1'b0, x} + {1'b0, y} + {32'd0, z};
		case (op_q)
			iacr_pkg::OP_ADD:   alu_r = a_q + b_q;
			iacr_pkg::OP_ADDI:  alu_r = ra0 + imm_q;
			iacr_pkg::OP_ADDIS: alu_r = ra0 + {imm_q[15:0], 16'd0};
			iacr_pkg::OP_ADDIC, iacr_pkg::OP_ADDE, iacr_pkg::OP_ADDZE,
			iacr_pkg::OP_SUBFC, iacr_pkg::OP_SUBFIC, iacr_pkg::OP_SUBFE,
			iacr_pkg::OP_SUBFME, iacr_pkg::OP_SUBFZE: begin
				alu_r = s3[31:0];
				alu_c = s3[32];
			end
			iacr_pkg::OP_SUBF: alu_r = b_q - a_q;
			iacr_pkg::OP_ABS:  alu_r = a_q[31] ? (32'd0 - a_q) : a_q;
			iacr_pkg::OP_NABS: alu_r = a_q[31] ? a_q : (32'd0 - a_q);
			iacr_pkg::OP_NEG:  alu_r = 32'd0 - a_q;
			default: alu_r = rt_val_q;
		endcase
	end

	// multiplier: 33x33 signed covers all forms
	logic signed [32:0] ma, mb;
	logic signed [65:0] mp;
	always_comb begin
		ma = {op_q == iacr_pkg::OP_MULHW & a_q[31], a_q};
		mb = (op_q == iacr_pkg::OP_MULLI) ? {imm_q[31], imm_q} :
			{op_q == iacr_pkg::OP_MULHW & b_q[31], b_q};
		mp = ma * mb;
	end

	// divider magnitudes
	logic [31:0] mag_a, mag_b;
	logic        sgn;
	always_comb begin
		sgn   = (op_q == iacr_pkg::OP_DIVW);
		mag_a = (sgn & a_q[31]) ? (32'd0 - a_q) : a_q;
		mag_b = (sgn & b_q[31]) ? (32'd0 - b_q) : b_q;
	end
	logic [32:0] dv_trial;
	always_comb dv_trial = {dv_rem_q, dv_quo_q[31]} - {1'b0, dv_den_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= operation;
			rt_q   <= dest_index;
			ra_i_q <= src_a_index;
			rb_i_q <= src_b_index;
			imm_q  <= {{16{immediate[15]}}, immediate};
			rec_q  <= record_flag;
		end
		if (cmd.read) begin
			a_q      <= rd(ra_i_q, rf_q, rf_vld_q);
			b_q      <= rd(rb_i_q, rf_q, rf_vld_q);
			rt_val_q <= rd(rt_q, rf_q, rf_vld_q);
		end
		if (cmd.exec) begin
			res_q <= alu_r;
			nc_q  <= alu_c;
			wr_q  <= (32'(op_q) <= iacr_pkg::OpLast);
		end
		if (cmd.mul) begin
			res_q <= (op_q == iacr_pkg::OP_MULHW || op_q == iacr_pkg::OP_MULHWU) ?
				mp[63:32] : mp[31:0];
			nc_q  <= carry_q;
			wr_q  <= 1'b1;
		end
		if (cmd.div_start) begin
			dv_quo_q  <= mag_a;
			dv_rem_q  <= 32'd0;
			dv_den_q  <= mag_b;
			dv_cnt_q  <= 6'd32;
			dv_neg_q  <= sgn & (a_q[31] ^ b_q[31]);
			dv_zero_q <= (b_q == 32'd0) ||
				(sgn && a_q == 32'h8000_0000 && b_q == 32'hFFFF_FFFF);
		end else if (cmd.div_step) begin
			if (dv_cnt_q != 6'd0) begin
				dv_cnt_q <= dv_cnt_q - 6'd1;
				if (!dv_trial[32]) begin
					dv_rem_q <= dv_trial[31:0];
					dv_quo_q <= {dv_quo_q[30:0], 1'b1};
				end else begin
					dv_rem_q <= {dv_rem_q[30:0], dv_quo_q[31]};
					dv_quo_q <= {dv_quo_q[30:0], 1'b0};
				end
			end else begin
				res_q <= dv_zero_q ? 32'd0 : (dv_neg_q ? (32'd0 - dv_quo_q) : dv_quo_q);
				nc_q  <= carry_q;
				wr_q  <= 1'b1;
			end
		end
		if (cmd.finish && wr_q && 32'(rt_q) < REG_COUNT) begin
			rf_q[rt_q[IdxW-1:0]] <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			carry_q  <= 1'b0;
			cond_q   <= 3'd0;
		end else if (cmd.finish && wr_q) begin
			if (32'(rt_q) < REG_COUNT) rf_vld_q[rt_q[IdxW-1:0]] <= 1'b1;
			carry_q <= nc_q;
			if (rec_q) begin
				if (res_q == 32'd0) cond_q <= iacr_pkg::CR_EQ;
				else if (res_q[31]) cond_q <= iacr_pkg::CR_LT;
				else cond_q <= iacr_pkg::CR_GT;
			end
		end
	end

	assign written_index = rt_q;
	assign written_value = res_q;
	assign carry_now     = carry_q;
	assign cond_now      = cond_q;

	logic unused;
	assign unused = cmd.out_take;
endmodule
`default_nettype wire

FILE: src/iacr_checker.sv
`default_nettype none
`include "assert_macros.svh"
module iacr_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [31:0] written_value,
	input wire [2:0]  cond_now
);
	`ASSERT_IMPL(a_one_at_a_time, clk, arst_n, out_valid, !in_ready)
	`ASSERT_NEXT(a_accept_blocks, clk, arst_n, in_valid && in_ready, !in_ready && !out_valid)
	`ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(written_value))
	`ASSERT_IMPL(a_cond_onehot, clk, arst_n, out_valid, $onehot0(cond_now))
endmodule

bind integer_alu_with_carry_and_cr0 iacr_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.written_value, .cond_now
);
`default_nettype wire
